// File: rtl/core/bvt_pkg.sv
// ----------------------------------------------------------------------------
// bvt_pkg
// Shared types and codes for the bounded vector table: opcode and status
// codes, default sizes, and the packed input and result words.
// ----------------------------------------------------------------------------
package bvt_pkg;

  // default sizing of the table
  localparam int CAPACITY_DEF   = 16;
  localparam int VALUE_BITS_DEF = 32;

  // opcodes
  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_ERASE  = 2'd1;
  localparam logic [1:0] OP_FIND   = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  // input word
  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] item_value;
    logic [3:0]  position;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  found_position;
    logic [31:0] read_value;
    logic [4:0]  entry_count;
    logic        is_empty;
  } out_word_t;

endpackage

// File: rtl/core/bvt_ram.sv
// ----------------------------------------------------------------------------
// bvt_ram
// Generic single-clock RAM with one write port and one read port; the read
// data is registered.
// ----------------------------------------------------------------------------
module bvt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/bounded_vector_table_top.sv
// ----------------------------------------------------------------------------
// bounded_vector_table_top
// Fixed-capacity ordered table of value words with append, erase, find and
// read, walked one entry per cycle by a small sequencer over one RAM.
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake                  word
//   in        input       in_valid_i / in_ready_o    in_word_i  (in_word_t)
//   out       output      out_valid_o / out_ready_i  out_word_o (out_word_t)
//
// Append writes the RAM on accept and goes through S_FINISH; read goes through
// S_READ, where the registered RAM data arrives, then S_FINISH. Find and erase
// both walk the table one entry per cycle through the single RAM read port.
// in_ready_o is high only while the sequencer is idle; one result register
// lets the next word be accepted while the previous result waits.
// rst_ni clears count and control; the table holds no reset and needs no
// clearing pass, since only live entries are ever read.
// ----------------------------------------------------------------------------
module bounded_vector_table_top
  import bvt_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  localparam int AW    = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_FIND,
    S_ERASE,
    S_FINISH
  } state_e;

  state_e                state_q, state_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [CNT_W-1:0]      idx_q, idx_d;
  logic                  pend_q, pend_d;
  logic [CNT_W-1:0]      pend_idx_q, pend_idx_d;
  logic                  out_valid_q, out_valid_d;
  out_word_t             out_q, out_d;
  logic [VALUE_BITS-1:0] val_q, val_d;
  logic [1:0]            res_status_q, res_status_d;
  logic [3:0]            res_found_q, res_found_d;
  logic [31:0]           res_rdval_q, res_rdval_d;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [VALUE_BITS-1:0] ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [VALUE_BITS-1:0] ram_rdata;

  logic                  pos_in_range;
  logic [CNT_W-1:0]      dst_idx;

  assign pos_in_range = CMP_W'(in_word_i.position) < CMP_W'(count_q);
  assign dst_idx      = pend_idx_q - CNT_W'(1);

  // entry storage
  bvt_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // sequencer next state
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    idx_d        = idx_q;
    pend_d       = pend_q;
    pend_idx_d   = pend_idx_q;
    val_d        = val_q;
    res_status_d = res_status_q;
    res_found_d  = res_found_q;
    res_rdval_d  = res_rdval_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q & ~out_ready_i;
    ram_we       = 1'b0;
    ram_waddr    = idx_q[AW-1:0];
    ram_wdata    = val_q;
    ram_raddr    = idx_q[AW-1:0];

    unique case (state_q)
      S_IDLE: begin
        ram_raddr = AW'(in_word_i.position);
        if (in_valid_i) begin
          res_status_d = ST_OK;
          res_found_d  = '0;
          res_rdval_d  = '0;
          val_d        = VALUE_BITS'(in_word_i.item_value);
          idx_d        = '0;
          pend_d       = 1'b0;
          unique case (in_word_i.opcode)
            OP_APPEND: begin
              if (count_q >= CNT_W'(CAPACITY)) begin
                res_status_d = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = count_q[AW-1:0];
                ram_wdata = VALUE_BITS'(in_word_i.item_value);
                count_d   = count_q + CNT_W'(1);
              end
              state_d = S_FINISH;
            end
            OP_ERASE: begin
              if (pos_in_range) begin
                idx_d   = CNT_W'(in_word_i.position) + CNT_W'(1);
                state_d = S_ERASE;
              end else begin
                res_status_d = ST_RANGE;
                state_d      = S_FINISH;
              end
            end
            OP_FIND: begin
              state_d = S_FIND;
            end
            OP_READ: begin
              if (pos_in_range) begin
                state_d = S_READ;
              end else begin
                res_status_d = ST_RANGE;
                state_d      = S_FINISH;
              end
            end
          endcase
        end
      end

      // registered read data arrives
      S_READ: begin
        res_rdval_d = 32'(ram_rdata);
        state_d     = S_FINISH;
      end

      // issue one read per cycle, compare the one that came back
      S_FIND: begin
        if (pend_q && (ram_rdata == val_q)) begin
          res_status_d = ST_OK;
          res_found_d  = 4'(pend_idx_q);
          pend_d       = 1'b0;
          state_d      = S_FINISH;
        end else if (idx_q < count_q) begin
          ram_raddr  = idx_q[AW-1:0];
          pend_d     = 1'b1;
          pend_idx_d = idx_q;
          idx_d      = idx_q + CNT_W'(1);
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            res_status_d = ST_NOTFOUND;
            state_d      = S_FINISH;
          end
        end
      end

      // read entry i+1, write it to entry i in the following cycle
      S_ERASE: begin
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = dst_idx[AW-1:0];
          ram_wdata = ram_rdata;
        end
        if (idx_q < count_q) begin
          ram_raddr  = idx_q[AW-1:0];
          pend_d     = 1'b1;
          pend_idx_d = idx_q;
          idx_d      = idx_q + CNT_W'(1);
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            count_d = count_q - CNT_W'(1);
            state_d = S_FINISH;
          end
        end
      end

      // hand the result to the output register once it is free
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.status         = res_status_q;
          out_d.found_position = res_found_q;
          out_d.read_value     = res_rdval_q;
          out_d.entry_count    = 5'(count_q);
          out_d.is_empty       = (count_q == '0);
          out_valid_d          = 1'b1;
          state_d              = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pend_idx_q   <= pend_idx_d;
    val_q        <= val_d;
    res_status_q <= res_status_d;
    res_found_q  <= res_found_d;
    res_rdval_q  <= res_rdval_d;
    out_q        <= out_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// File: verif/bounded_vector_table_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bounded_vector_table_checker
// Passive monitor for the bounded vector table. It keeps a shadow copy of the
// table contents and live count. On every accepted input word it computes
// the result the block must return and queues it. On every accepted result
// word it compares each field against the oldest queued result.
// ----------------------------------------------------------------------------
module bounded_vector_table_checker
  import bvt_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_word_t  in_word_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_word_t out_word_i,
  output int        fail_count_o,
  output int        pending_o
);

  localparam logic [31:0] VALUE_MASK =
    (VALUE_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << VALUE_BITS) - 64'd1);

  // shadow of the table
  logic [31:0] shadow_entries [CAPACITY];
  int          shadow_count;

  out_word_t   expected_results [$];
  int          fails;

  // apply one operation to the shadow table and return the result word
  function automatic out_word_t apply_table_op(in_word_t w);
    out_word_t   r;
    logic [31:0] v;
    int          idx;
    int          pos;
    r   = '0;
    v   = w.item_value & VALUE_MASK;
    pos = int'(w.position);
    r.status = ST_OK;
    case (w.opcode)
      OP_APPEND: begin
        if (shadow_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          shadow_entries[shadow_count] = v;
          shadow_count++;
        end
      end
      OP_ERASE: begin
        if (pos < shadow_count && pos < CAPACITY) begin
          // close the gap over live entries only
          for (idx = pos; idx + 1 < shadow_count && idx + 1 < CAPACITY; idx++) begin
            shadow_entries[idx] = shadow_entries[idx + 1];
          end
          shadow_count--;
        end else begin
          r.status = ST_RANGE;
        end
      end
      OP_FIND: begin
        r.status = ST_NOTFOUND;
        for (idx = 0; idx < shadow_count && idx < CAPACITY; idx++) begin
          if (shadow_entries[idx] == v) begin
            r.status         = ST_OK;
            r.found_position = 4'(idx);
            break;
          end
        end
      end
      default: begin
        if (pos < shadow_count && pos < CAPACITY) begin
          r.read_value = shadow_entries[pos];
        end else begin
          r.status = ST_RANGE;
        end
      end
    endcase
    r.entry_count = 5'(shadow_count);
    r.is_empty    = (shadow_count == 0);
    return r;
  endfunction

  // report one field that differs
  function automatic int field_mismatch(string name, longint unsigned want,
                                        longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // watch both channels; results are retired before new words are queued
  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t want;
    if (!rst_ni) begin
      expected_results.delete();
      shadow_count = 0;
      fails        = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("result word with no pending expectation: %0h", out_word_i);
          fails++;
        end else begin
          want = expected_results.pop_front();
          fails += field_mismatch("status", want.status, out_word_i.status)
                 + field_mismatch("found_position", want.found_position,
                                  out_word_i.found_position)
                 + field_mismatch("read_value", want.read_value, out_word_i.read_value)
                 + field_mismatch("entry_count", want.entry_count, out_word_i.entry_count)
                 + field_mismatch("is_empty", want.is_empty, out_word_i.is_empty);
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_results.insert(expected_results.size(), apply_table_op(in_word_i));
      end
      fail_count_o <= fails;
      pending_o    <= expected_results.size();
    end
  end

endmodule

// File: verif/bounded_vector_table_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bounded_vector_table_top_test
// Stimulus and verdict for the bounded vector table. A directed run walks
// the empty and full table, both value extremes, duplicates and every
// out-of-range case; random words follow under three idle profiles, with a
// long result hold-off that backs the block up. A checker compares results.
// ----------------------------------------------------------------------------
module bounded_vector_table_top_test;
  import bvt_pkg::*;

  localparam int ITEMS_PER_PHASE = 367;
  localparam int HOLD_CYCLES     = 300;
  localparam int DRAIN_CYCLES    = 40;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_word_t  in_word   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_word;

  int        fail_count;
  int        pending;
  int        phase     = 0;
  int        tx_idle   = 0;

  bounded_vector_table_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word)
  );

  bounded_vector_table_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_word_i    (in_word),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_word_i   (out_word),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic in_word_t make_word(logic [1:0] op, logic [31:0] val,
                                         logic [3:0] pos);
    in_word_t w;
    w.opcode     = op;
    w.item_value = val;
    w.position   = pos;
    return w;
  endfunction

  // values from a small pool collide often, so finds hit
  function automatic logic [31:0] pick_value();
    case ($urandom_range(3))
      0:       return 32'($urandom_range(7));
      1:       return 32'hFFFF_FFF8 | 32'($urandom_range(7));
      default: return $urandom;
    endcase
  endfunction

  // random word, biased toward filling or emptying the table
  function automatic in_word_t random_word(bit grow);
    int         roll;
    logic [1:0] op;
    roll = $urandom_range(99);
    if (grow) begin
      op = (roll < 50) ? OP_APPEND : (roll < 60) ? OP_ERASE :
           (roll < 80) ? OP_FIND : OP_READ;
    end else begin
      op = (roll < 10) ? OP_APPEND : (roll < 50) ? OP_ERASE :
           (roll < 75) ? OP_FIND : OP_READ;
    end
    return make_word(op, pick_value(), 4'($urandom_range(15)));
  endfunction

  // offer one word after a random gap, hold it until accepted
  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  // result side: random stalls per phase, one long hold-off entering phase 2
  initial begin
    int hold_left;
    int seen_phase;
    int rx_idle;
    hold_left  = 0;
    seen_phase = 0;
    forever begin
      @(posedge clk_i);
      if (phase != seen_phase && phase == 2) hold_left = HOLD_CYCLES;
      seen_phase = phase;
      rx_idle = (phase == 0) ? 66 : (phase == 1) ? 26 : 0;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle);
      end
    end
  end

  // reset, stimulus and verdict
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    tx_idle = 26;

    // empty table: find, read and erase all miss
    send_word(make_word(OP_FIND, 32'h0, 4'd0));
    send_word(make_word(OP_READ, 32'h0, 4'd0));
    send_word(make_word(OP_ERASE, 32'h0, 4'd0));
    send_word(make_word(OP_READ, 32'hFFFF_FFFF, 4'd15));
    // fill to capacity with extremes and duplicates
    send_word(make_word(OP_APPEND, 32'h0000_0000, 4'd0));
    send_word(make_word(OP_APPEND, 32'hFFFF_FFFF, 4'd15));
    for (int k = 0; k < CAPACITY_DEF - 2; k++) begin
      send_word(make_word(OP_APPEND, (k % 2) ? 32'hA5A5_5A5A : 32'(k), 4'(k)));
    end
    // append when full
    send_word(make_word(OP_APPEND, 32'h1234_5678, 4'd0));
    send_word(make_word(OP_READ, 32'h0, 4'd15));
    send_word(make_word(OP_FIND, 32'hFFFF_FFFF, 4'd0));
    // duplicate value: first match wins
    send_word(make_word(OP_FIND, 32'hA5A5_5A5A, 4'd0));
    // erase the last entry, then the first
    send_word(make_word(OP_ERASE, 32'h0, 4'd15));
    send_word(make_word(OP_ERASE, 32'h0, 4'd0));
    // index now past the count
    send_word(make_word(OP_READ, 32'h0, 4'd15));
    send_word(make_word(OP_FIND, 32'h1234_5678, 4'd0));

    // random words under three idle profiles
    for (int p = 0; p < 3; p++) begin
      phase   <= p;
      tx_idle  = (p == 0) ? 26 : (p == 1) ? 66 : 0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_word(random_word(((n / 50) % 2) == 0));
      end
    end
    in_valid <= 1'b0;

    // drain
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/bvt_pkg.sv
rtl/core/bvt_ram.sv
rtl/core/bounded_vector_table_top.sv
verif/bounded_vector_table_checker.sv
verif/bounded_vector_table_top_test.sv
